// ===== sv/detection_box_decode_assert.svh =====
// Assertion macros shared by the detection box decoder RTL files.
`ifndef DETECTION_BOX_DECODE_ASSERT_SVH
`define DETECTION_BOX_DECODE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define DBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("detection_box_decode: assertion failed");
// Next-cycle implication, disabled while in reset
`define DBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("detection_box_decode: assertion failed");
`else
`define DBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/dbd_pkg.sv =====
// Shared types and constants for the detection box decoder.
package dbd_pkg;

  // Parameter defaults
  localparam int MAX_BATCH_DEF       = 64;
  localparam int MAX_FRAME_DIM_DEF   = 8192;
  localparam int COORD_FRAC_BITS_DEF = 14;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Saturated frame size fits 15 bits for any allowed MAX_FRAME_DIM
  localparam int DIM_W = 15;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_COUNT = 2'd2;

  // Reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd16384;
  localparam logic [15:0] SCALE_ONE     = 16'd4096;
  localparam logic [15:0] LABELS_RST    = 16'd0;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] box_scale;
    logic [15:0] label_count;
  } dbd_cfg_t;

  // One kept proposal, as queued between front and back
  typedef struct packed {
    logic [5:0]         image;
    logic signed [15:0] class_id;
    logic               known;
    logic [15:0]        score;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } dbd_item_t;

endpackage

// ===== sv/dbd_front.sv =====
// Front end: accepts proposals, tracks the layer stop flag and filters items.
`include "detection_box_decode_assert.svh"
module dbd_front import dbd_pkg::*; #(
  parameter int MAX_BATCH     = MAX_BATCH_DEF,
  parameter int MAX_FRAME_DIM = MAX_FRAME_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dbd_cfg_t           cfg,
  input  logic               in_valid,
  input  logic               q_full,
  input  logic               in_first_proposal,
  input  logic signed [7:0]  in_image_index,
  input  logic signed [15:0] in_class_id,
  input  logic [15:0]        in_score,
  input  logic signed [15:0] in_left_norm,
  input  logic signed [15:0] in_top_norm,
  input  logic signed [15:0] in_right_norm,
  input  logic signed [15:0] in_bottom_norm,
  input  logic [13:0]        in_frame_width,
  input  logic [13:0]        in_frame_height,
  input  logic [6:0]         in_batch_size,
  output logic               push,
  output dbd_item_t          push_item
);

  localparam logic [7:0]       BATCH_LIM = 8'(MAX_BATCH);
  localparam logic [DIM_W-1:0] DIM_LIM   = DIM_W'(MAX_FRAME_DIM);

  logic             stopped_r, stopped_nxt;
  logic             acc, stopped_eff, oor, keep;
  logic [7:0]       batch_sat;
  logic [DIM_W-1:0] fw_ext, fh_ext;

  // Classification of the item on the input port
  always_comb begin
    acc         = in_valid && !q_full;
    stopped_eff = in_first_proposal ? 1'b0 : stopped_r;
    batch_sat   = ({1'b0, in_batch_size} > BATCH_LIM) ? BATCH_LIM : {1'b0, in_batch_size};
    oor         = in_image_index[7] || ({1'b0, in_image_index[6:0]} >= batch_sat);
    keep        = !stopped_eff && !oor && (in_score >= cfg.threshold);
    push        = acc && keep;
    stopped_nxt = acc ? (stopped_eff || oor) : stopped_r;
  end

  // Queue entry: clamp frame sizes, flag known labels
  always_comb begin
    fw_ext = {1'b0, in_frame_width};
    fh_ext = {1'b0, in_frame_height};
    push_item.image    = in_image_index[5:0];
    push_item.class_id = in_class_id;
    push_item.known    = !in_class_id[15] && ({1'b0, in_class_id[14:0]} < cfg.label_count);
    push_item.score    = in_score;
    push_item.left     = in_left_norm;
    push_item.top      = in_top_norm;
    push_item.right    = in_right_norm;
    push_item.bottom   = in_bottom_norm;
    push_item.width    = (fw_ext > DIM_LIM) ? DIM_LIM : fw_ext;
    push_item.height   = (fh_ext > DIM_LIM) ? DIM_LIM : fh_ext;
  end

  // Layer stop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
    end else begin
      stopped_r <= stopped_nxt;
    end
  end

  `DBD_ASSERT_IMP(a_fr_stop_cause, clk, rst_n, $rose(stopped_r), $past(acc))
  `DBD_ASSERT_IMP(a_fr_push_live, clk, rst_n, push, !stopped_nxt && !q_full)

endmodule

// ===== sv/dbd_queue.sv =====
// Short queue of kept items between front and back.
`include "detection_box_decode_assert.svh"
module dbd_queue import dbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dbd_item_t push_item,
  input  logic      pop,
  output dbd_item_t head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dbd_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `DBD_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, !empty)
  `DBD_ASSERT_NXT(a_q_count_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// ===== sv/dbd_back.sv =====
// Back end: box scaling, pixel conversion and the output register.
module dbd_back import dbd_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [15:0]             box_scale,
  input  dbd_item_t               head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [5:0]              out_image,
  output logic signed [15:0]      out_class,
  output logic                    out_class_known,
  output logic [15:0]             out_score,
  output logic signed [15:0]      out_scaled_left,
  output logic signed [15:0]      out_scaled_top,
  output logic signed [15:0]      out_scaled_right,
  output logic signed [15:0]      out_scaled_bottom,
  output logic [14:0]             out_pixel_left,
  output logic [14:0]             out_pixel_top,
  output logic signed [14:0]      out_pixel_right,
  output logic signed [14:0]      out_pixel_bottom
);

  localparam logic signed [32:0] PIX_HALF = 33'sd1 <<< (COORD_FRAC_BITS - 1);
  localparam logic signed [32:0] PIX_MASK = (33'sd1 <<< COORD_FRAC_BITS) - 33'sd1;

  // Round to Q2.14 after scaling one edge about the centre, then saturate
  function automatic logic signed [15:0] scale_edge(input logic signed [16:0] sum,
                                                    input logic signed [33:0] half,
                                                    input logic               lower);
    logic signed [34:0] ctr, half_e, tot;
    logic signed [21:0] q;
    ctr    = {{6{sum[16]}}, sum, 12'b0};
    half_e = {half[33], half};
    tot    = lower ? (ctr - half_e + 35'sd4096) : (ctr + half_e + 35'sd4096);
    q      = tot[34:13];
    if (q > 22'sd32767) begin
      scale_edge = 16'sh7FFF;
    end else if (q < -22'sd32768) begin
      scale_edge = 16'sh8000;
    end else begin
      scale_edge = q[15:0];
    end
  endfunction

  // Add a half and truncate toward zero
  function automatic logic signed [32:0] to_pixel(input logic signed [31:0] prod);
    logic signed [32:0] t, adj;
    t   = {prod[31], prod} + PIX_HALF;
    adj = t[32] ? (t + PIX_MASK) : t;
    to_pixel = adj >>> COORD_FRAC_BITS;
  endfunction

  logic advance;

  // Stage 2: centre sums and half-size products
  logic                s2_valid_r, s2_bypass_r;
  dbd_item_t           s2_item_r;
  logic signed [16:0]  s2_sum_x_r, s2_sum_y_r;
  logic signed [33:0]  s2_half_x_r, s2_half_y_r;
  logic signed [16:0]  sum_x_nxt, sum_y_nxt, dif_x, dif_y;
  logic signed [16:0]  scale_s;
  logic signed [33:0]  half_x_nxt, half_y_nxt;

  // Stage 3: scaled box
  logic                s3_valid_r;
  dbd_item_t           s3_item_r, s3_item_nxt;

  // Stage 4: coordinate times frame size
  logic                s4_valid_r;
  dbd_item_t           s4_item_r;
  logic signed [31:0]  s4_prod_l_r, s4_prod_t_r, s4_prod_r_r, s4_prod_b_r;
  logic signed [15:0]  w_s, h_s;

  // Output stage
  logic                out_valid_r;
  logic signed [32:0]  pl_raw, pt_raw, pr_raw, pb_raw, w_ext, h_ext;
  logic signed [32:0]  pl_nxt, pt_nxt, pr_nxt, pb_nxt;
  dbd_item_t           out_item_r;
  logic [14:0]         pl_r, pt_r, pr_r, pb_r;

  // Whole pipeline holds while a result waits
  assign advance = !(out_valid_r && out_stall);
  assign pop     = advance && !empty;

  always_comb begin
    scale_s    = $signed({1'b0, box_scale});
    sum_x_nxt  = $signed({head.left[15], head.left}) + $signed({head.right[15], head.right});
    sum_y_nxt  = $signed({head.top[15], head.top}) + $signed({head.bottom[15], head.bottom});
    dif_x      = $signed({head.right[15], head.right}) - $signed({head.left[15], head.left});
    dif_y      = $signed({head.bottom[15], head.bottom}) - $signed({head.top[15], head.top});
    half_x_nxt = dif_x * scale_s;
    half_y_nxt = dif_y * scale_s;
  end

  always_comb begin
    s3_item_nxt = s2_item_r;
    if (!s2_bypass_r) begin
      s3_item_nxt.left   = scale_edge(s2_sum_x_r, s2_half_x_r, 1'b1);
      s3_item_nxt.right  = scale_edge(s2_sum_x_r, s2_half_x_r, 1'b0);
      s3_item_nxt.top    = scale_edge(s2_sum_y_r, s2_half_y_r, 1'b1);
      s3_item_nxt.bottom = scale_edge(s2_sum_y_r, s2_half_y_r, 1'b0);
    end
  end

  assign w_s = $signed({1'b0, s3_item_r.width});
  assign h_s = $signed({1'b0, s3_item_r.height});

  // Pixel rounding and clamping
  always_comb begin
    w_ext  = $signed({18'b0, s4_item_r.width});
    h_ext  = $signed({18'b0, s4_item_r.height});
    pl_raw = to_pixel(s4_prod_l_r);
    pt_raw = to_pixel(s4_prod_t_r);
    pr_raw = to_pixel(s4_prod_r_r);
    pb_raw = to_pixel(s4_prod_b_r);
    pl_nxt = pl_raw[32] ? 33'sd0 : pl_raw;
    pt_nxt = pt_raw[32] ? 33'sd0 : pt_raw;
    pr_nxt = (pr_raw > w_ext) ? w_ext : pr_raw;
    pb_nxt = (pb_raw > h_ext) ? h_ext : pb_raw;
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r  <= !empty;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_item_r   <= head;
      s2_bypass_r <= (box_scale == 16'd0) || (box_scale == SCALE_ONE);
      s2_sum_x_r  <= sum_x_nxt;
      s2_sum_y_r  <= sum_y_nxt;
      s2_half_x_r <= half_x_nxt;
      s2_half_y_r <= half_y_nxt;
      s3_item_r   <= s3_item_nxt;
      s4_item_r   <= s3_item_r;
      s4_prod_l_r <= s3_item_r.left * w_s;
      s4_prod_r_r <= s3_item_r.right * w_s;
      s4_prod_t_r <= s3_item_r.top * h_s;
      s4_prod_b_r <= s3_item_r.bottom * h_s;
      out_item_r  <= s4_item_r;
      pl_r        <= pl_nxt[14:0];
      pt_r        <= pt_nxt[14:0];
      pr_r        <= pr_nxt[14:0];
      pb_r        <= pb_nxt[14:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_image         = out_item_r.image;
  assign out_class         = out_item_r.class_id;
  assign out_class_known   = out_item_r.known;
  assign out_score         = out_item_r.score;
  assign out_scaled_left   = out_item_r.left;
  assign out_scaled_top    = out_item_r.top;
  assign out_scaled_right  = out_item_r.right;
  assign out_scaled_bottom = out_item_r.bottom;
  assign out_pixel_left    = pl_r;
  assign out_pixel_top     = pt_r;
  assign out_pixel_right   = $signed(pr_r);
  assign out_pixel_bottom  = $signed(pb_r);

endmodule

// ===== sv/detection_box_decode.sv =====
// Top level of the detection box decoder: configuration registers and block wiring.
//
// Input channel (in_*): one detection proposal per item, taken when in_valid is
// high and in_stall is low. Proposals of a stopped layer, proposals with an
// image index outside the batch and proposals under the confidence threshold
// give no result; an out-of-range index stops the layer until the next item
// marked first_proposal.
// Result channel (out_*): one item per kept proposal, taken when out_valid is
// high and out_stall is low; a held result keeps its payload.
// Configuration: cfg_we writes cfg_data[15:0] to the register cfg_index selects
// (0 threshold, 1 box scale, 2 label count); write only while the block is idle.
// Throughput: one item per cycle while no stall holds the flow, set by the
// combinational front classifier and the 4-stage back pipeline; a 4-entry
// queue (QUEUE_DEPTH) between them absorbs stalls. When out_stall is held
// while a result waits, the back pipeline freezes, the queue fills and then
// in_stall rises. Reset (rst_n low, synchronous) empties the queue and the
// pipeline, clears the layer stop flag and loads the register reset values.
module detection_box_decode import dbd_pkg::*; #(
  parameter int MAX_BATCH       = MAX_BATCH_DEF,
  parameter int MAX_FRAME_DIM   = MAX_FRAME_DIM_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_first_proposal,
  input  logic signed [7:0]    in_image_index,
  input  logic signed [15:0]   in_class_id,
  input  logic [15:0]          in_score,
  input  logic signed [15:0]   in_left_norm,
  input  logic signed [15:0]   in_top_norm,
  input  logic signed [15:0]   in_right_norm,
  input  logic signed [15:0]   in_bottom_norm,
  input  logic [13:0]          in_frame_width,
  input  logic [13:0]          in_frame_height,
  input  logic [6:0]           in_batch_size,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           out_image,
  output logic signed [15:0]   out_class,
  output logic                 out_class_known,
  output logic [15:0]          out_score,
  output logic signed [15:0]   out_scaled_left,
  output logic signed [15:0]   out_scaled_top,
  output logic signed [15:0]   out_scaled_right,
  output logic signed [15:0]   out_scaled_bottom,
  output logic [14:0]          out_pixel_left,
  output logic [14:0]          out_pixel_top,
  output logic signed [14:0]   out_pixel_right,
  output logic signed [14:0]   out_pixel_bottom
);

  dbd_cfg_t  cfg_r, cfg_nxt;
  logic      push, pop, q_full, q_empty;
  dbd_item_t push_item, head;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:   cfg_nxt.threshold   = cfg_data;
        REG_BOX_SCALE:   cfg_nxt.box_scale   = cfg_data;
        REG_LABEL_COUNT: cfg_nxt.label_count = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= THRESHOLD_RST;
      cfg_r.box_scale   <= SCALE_ONE;
      cfg_r.label_count <= LABELS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = q_full;

  dbd_front #(
    .MAX_BATCH     (MAX_BATCH),
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .q_full            (q_full),
    .in_first_proposal (in_first_proposal),
    .in_image_index    (in_image_index),
    .in_class_id       (in_class_id),
    .in_score          (in_score),
    .in_left_norm      (in_left_norm),
    .in_top_norm       (in_top_norm),
    .in_right_norm     (in_right_norm),
    .in_bottom_norm    (in_bottom_norm),
    .in_frame_width    (in_frame_width),
    .in_frame_height   (in_frame_height),
    .in_batch_size     (in_batch_size),
    .push              (push),
    .push_item         (push_item)
  );

  dbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dbd_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .box_scale         (cfg_r.box_scale),
    .head              (head),
    .empty             (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_image         (out_image),
    .out_class         (out_class),
    .out_class_known   (out_class_known),
    .out_score         (out_score),
    .out_scaled_left   (out_scaled_left),
    .out_scaled_top    (out_scaled_top),
    .out_scaled_right  (out_scaled_right),
    .out_scaled_bottom (out_scaled_bottom),
    .out_pixel_left    (out_pixel_left),
    .out_pixel_top     (out_pixel_top),
    .out_pixel_right   (out_pixel_right),
    .out_pixel_bottom  (out_pixel_bottom)
  );

endmodule
